// ===== rtl/core/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 message hash.
// Used by the front, queue, engine and top level; depends on nothing.
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [31:0] word;
    logic        pad_start;
    logic        last;
  } qitem_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_UPDATE,
    ENG_PAD,
    ENG_EMIT
  } eng_state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== rtl/core/sha256_front.sv =====
// Input front end: takes message words, masks the final word and adds the 0x80 byte.
// Depends on sha256_pkg for the queue item type.
module sha256_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic [31:0]         data_word,
  input  logic [2:0]          valid_bytes,
  input  logic                final_word,
  output logic                q_valid,
  input  logic                q_stall,
  output sha256_pkg::qitem_t  q_item
);

  logic [2:0]  nbytes;
  logic [31:0] keep;
  logic [31:0] marked;
  logic        pend;
  logic        pend_next;

  always_comb begin
    nbytes = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    keep   = (nbytes == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nbytes, 3'b000}));
    marked = (data_word & keep);
    if (nbytes != 3'd4) begin
      marked = marked | ({24'h0, sha256_pkg::PAD_BYTE} << (5'd24 - {nbytes[1:0], 3'b000}));
    end
  end

  // A four-byte final word is followed by a separate 0x80 word.
  always_comb begin
    q_valid = valid || pend;
    stall   = q_stall || pend;
    if (pend) begin
      q_item.word      = {sha256_pkg::PAD_BYTE, 24'h0};
      q_item.pad_start = 1'b1;
      q_item.last      = 1'b1;
    end else if (final_word) begin
      q_item.word      = marked;
      q_item.pad_start = (nbytes != 3'd4);
      q_item.last      = (nbytes != 3'd4);
    end else begin
      q_item.word      = data_word;
      q_item.pad_start = 1'b0;
      q_item.last      = 1'b0;
    end
    pend_next = pend;
    if (pend && !q_stall) begin
      pend_next = 1'b0;
    end else if (!pend && valid && !q_stall && final_word && nbytes == 3'd4) begin
      pend_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= pend_next;
    end
  end

endmodule

// ===== rtl/core/sha256_queue.sv =====
// Small FIFO between the front end and the compression engine.
// Depends on sha256_pkg for the item type.
module sha256_queue #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha256_pkg::qitem_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sha256_pkg::qitem_t out_item
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha256_pkg::qitem_t mem [Depth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_stall  = (count == (AW+1)'(Depth));
  assign out_valid = (count != '0);
  assign out_item  = mem[rptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/sha256_engine.sv =====
// Compression engine: block buffer, padding, 64 rounds and digest output.
// Depends on sha256_pkg for constants, round functions and the state type.
module sha256_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_stall,
  input  sha256_pkg::qitem_t q_item,
  output logic               valid,
  input  logic               stall,
  output logic [31:0]        digest_word,
  output logic [2:0]         digest_index,
  output logic               digest_last
);

  sha256_pkg::eng_state_t state;
  sha256_pkg::eng_state_t state_next;

  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [63:0] bit_length;
  logic [3:0]  fill;
  logic [5:0]  round;
  logic        padding;
  logic        finishing;
  logic [2:0]  emit_idx;

  logic        take;
  logic        put_word;
  logic [31:0] put_val;
  logic [31:0] wt;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign take = (state == sha256_pkg::ENG_IDLE) && q_valid;

  // Schedule word for this round: the buffer is a sliding window of 16.
  always_comb begin
    w_new = sha256_pkg::small_sigma1(w[14]) + w[9] + sha256_pkg::small_sigma0(w[1]) + w[0];
    wt    = w[0];
    t1 = v[7] + sha256_pkg::big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha256_pkg::ROUND_K[round] + wt;
    t2 = sha256_pkg::big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // The length goes only into the block that finishes the message.
  always_comb begin
    put_word = 1'b0;
    put_val  = 32'h0;
    if (take) begin
      put_word = 1'b1;
      put_val  = q_item.word;
    end else if (state == sha256_pkg::ENG_PAD) begin
      put_word = 1'b1;
      if (finishing && fill == 4'd14) begin
        put_val = bit_length[63:32];
      end else if (finishing && fill == 4'd15) begin
        put_val = bit_length[31:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ENG_IDLE: begin
        if (take) begin
          if (fill == 4'd15) begin
            state_next = sha256_pkg::ENG_ROUND;
          end else if (q_item.pad_start) begin
            state_next = sha256_pkg::ENG_PAD;
          end
        end
      end
      sha256_pkg::ENG_PAD: begin
        if (fill == 4'd15) begin
          state_next = sha256_pkg::ENG_ROUND;
        end
      end
      sha256_pkg::ENG_ROUND: begin
        if (round == 6'd63) begin
          state_next = sha256_pkg::ENG_UPDATE;
        end
      end
      sha256_pkg::ENG_UPDATE: begin
        if (finishing) begin
          state_next = sha256_pkg::ENG_EMIT;
        end else if (padding) begin
          state_next = sha256_pkg::ENG_PAD;
        end else begin
          state_next = sha256_pkg::ENG_IDLE;
        end
      end
      sha256_pkg::ENG_EMIT: begin
        if (!stall && emit_idx == 3'd7) begin
          state_next = sha256_pkg::ENG_IDLE;
        end
      end
      default: state_next = sha256_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    q_stall      = (state != sha256_pkg::ENG_IDLE);
    valid        = (state == sha256_pkg::ENG_EMIT);
    digest_word  = h[emit_idx];
    digest_index = emit_idx;
    digest_last  = (emit_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (put_word) begin
      w[fill] <= put_val;
    end else if (state == sha256_pkg::ENG_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sha256_pkg::ENG_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= h[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha256_pkg::ENG_IDLE;
      bit_length <= '0;
      fill       <= '0;
      round      <= '0;
      padding    <= 1'b0;
      finishing  <= 1'b0;
      emit_idx   <= '0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= sha256_pkg::INIT_HASH[i];
      end
    end else begin
      state <= state_next;
      if (take) begin
        if (q_item.pad_start && q_item.last) begin
          bit_length <= bit_length + 64'({q_item.word[7:0] == 8'h80 ? 2'd3 :
            q_item.word[15:8] == 8'h80 ? 2'd2 : q_item.word[23:16] == 8'h80 ? 2'd1 : 2'd0,
            3'b000});
        end else if (!q_item.last) begin
          bit_length <= bit_length + 64'd32;
        end
        if (q_item.pad_start) begin
          padding   <= 1'b1;
          finishing <= (fill < 4'd14);
        end
      end
      if (put_word) begin
        fill <= fill + 1'b1;
      end
      if (state == sha256_pkg::ENG_ROUND) begin
        round <= round + 1'b1;
      end
      if (state == sha256_pkg::ENG_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          h[i] <= h[i] + v[i];
        end
        if (!finishing && padding) begin
          finishing <= 1'b1;
        end
      end
      if (state == sha256_pkg::ENG_EMIT && !stall) begin
        emit_idx <= emit_idx + 1'b1;
        if (emit_idx == 3'd7) begin
          padding    <= 1'b0;
          finishing  <= 1'b0;
          bit_length <= '0;
          for (int i = 0; i < 8; i++) begin
            h[i] <= sha256_pkg::INIT_HASH[i];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/sha256_message_hash.sv =====
// Top level of the SHA-256 message hash: front end, queue and compression engine.
// Depends on sha256_pkg, sha256_front, sha256_queue and sha256_engine.
//
// Channel   Direction  Handshake                  Payload
// message   in         valid/stall                data_word, valid_bytes, final_word
// digest    out        digest_valid/digest_stall  digest_word, digest_index, digest_last
//
// A full block takes 16 word transfers and then 64 rounds and one chain update in the single
// shared round unit.
// Padding fills the rest of the buffer and may add a second block.
// The digest leaves as eight transfers, one per cycle while digest_stall is low.
// Reset is synchronous; after it the block accepts a message at once.
module sha256_message_hash #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        final_word,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_last
);

  logic               fq_valid;
  logic               fq_stall;
  sha256_pkg::qitem_t fq_item;
  logic               qe_valid;
  logic               qe_stall;
  sha256_pkg::qitem_t qe_item;

  sha256_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .data_word(data_word),
    .valid_bytes(valid_bytes), .final_word(final_word),
    .q_valid(fq_valid), .q_stall(fq_stall), .q_item(fq_item)
  );

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .in_valid(fq_valid), .in_stall(fq_stall), .in_item(fq_item),
    .out_valid(qe_valid), .out_stall(qe_stall), .out_item(qe_item)
  );

  sha256_engine u_engine (
    .clk(clk), .rst(rst), .q_valid(qe_valid), .q_stall(qe_stall), .q_item(qe_item),
    .valid(digest_valid), .stall(digest_stall), .digest_word(digest_word),
    .digest_index(digest_index), .digest_last(digest_last)
  );

  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_stall |=> digest_valid && $stable(digest_word)
      && $stable(digest_index) && $stable(digest_last));

  a_digest_last: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest_last == (digest_index == 3'd7)));

  a_known_handshake: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({stall, digest_valid}));

  a_known_digest: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> !$isunknown({digest_word, digest_index, digest_last}));

endmodule
